FILE: hw/rtl/prime_factor_counter_assert.svh
// Assertion macros used by the checker file.
`ifndef PRIME_FACTOR_COUNTER_ASSERT_SVH
`define PRIME_FACTOR_COUNTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PFC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define PFC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/pfc_pkg.sv
package pfc_pkg;

	// Default sizing
	localparam int PRIME_LIMIT_DEF = 65536;
	localparam int PRIME_SLOTS_DEF = 8192;
	localparam int VALUE_BITS_DEF  = 31;

	// Result field
	localparam int COUNT_W = 5;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

FILE: hw/rtl/pfc_ram.sv
module pfc_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/pfc_div.sv
module pfc_div #(
	parameter int DW = 31,
	parameter int AW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [AW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot,
	output logic [AW-1:0] rem
);

	localparam int CNW = $clog2(DW + 1);

	logic           busy_q;
	logic           done_q;
	logic [CNW-1:0] cnt_q;
	logic [DW-1:0]  quo_q;
	logic [AW-1:0]  rem_q;
	logic [AW-1:0]  dvs_q;
	logic [AW:0]    trial;
	logic [AW:0]    diff;
	logic           ge;

	// Restoring step: one quotient bit per cycle
	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	// Control: start restarts, done pulses once at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[AW-1:0] : trial[AW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

FILE: hw/rtl/prime_factor_counter.sv
// prime_factor_counter: counts the prime factors of value, with multiplicity.
// Input channel in_valid/in_ready carries value; output channel out_valid/out_ready
// carries factor_count (saturates at 31; 0 and 1 give 0). One result per beat.
// After reset the block first clears the composite bitmap, one entry a cycle,
// then runs a linear sieve that fills the prime table; each sieve mark costs
// a multiply and an iterative remainder. in_ready stays low until the sieve
// is done.
// Per item: setup, then for each prime tried, a table read, a multiply for p*p
// and one remainder in the shared bit-serial divider, max(VALUE_BITS, log2
// PRIME_LIMIT) bits wide; each extra factor of the same prime costs one more
// remainder. Worst case near 4800 primes. The divider and the single table
// read port set the time per item.
// One item is worked on at a time. A finished result sits in an output register,
// so the next item is accepted while it waits; if the receiver stalls past the
// end of that next item, the block holds in its last state until the register
// frees up.
module prime_factor_counter #(
	parameter int PRIME_LIMIT = pfc_pkg::PRIME_LIMIT_DEF,
	parameter int PRIME_SLOTS = pfc_pkg::PRIME_SLOTS_DEF,
	parameter int VALUE_BITS  = pfc_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [VALUE_BITS-1:0]        value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pfc_pkg::COUNT_W-1:0]  factor_count
);

	import pfc_pkg::*;

	localparam int AW = $clog2(PRIME_LIMIT);
	localparam int TW = $clog2(PRIME_SLOTS);
	localparam int KW = $clog2(PRIME_SLOTS + 1);
	localparam int DW = (VALUE_BITS > AW) ? VALUE_BITS : AW;
	localparam int PW = 2 * AW;
	localparam int CW = (PW > DW) ? PW : DW;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_N_RD,
		S_N_CHK,
		S_K_RD,
		S_K_MUL,
		S_K_CHK,
		S_K_DIV,
		S_N_NEXT,
		S_IDLE,
		S_F_RD,
		S_F_MUL,
		S_F_CHK,
		S_F_DIV,
		S_F_OUT
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      n_q;
	logic [KW-1:0]      k_q;
	logic [KW-1:0]      total_q;
	logic [AW-1:0]      p_q;
	logic [PW-1:0]      prod_q;
	logic [DW-1:0]      x_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               out_valid_q;
	logic [COUNT_W-1:0] out_cnt_q;

	logic          comp_we;
	logic [AW-1:0] comp_waddr;
	logic [0:0]    comp_wdata;
	logic [0:0]    comp_rdata;
	logic          tbl_we;
	logic [AW-1:0] tbl_rdata;
	logic          div_start;
	logic [DW-1:0] div_dividend;
	logic          div_done;
	logic [DW-1:0] div_quot;
	logic [AW-1:0] div_rem;
	logic          div_exact;
	logic [COUNT_W-1:0] cnt_inc;
	logic [COUNT_W-1:0] cnt_fin;

	// Composite bitmap
	pfc_ram #(.DEPTH(PRIME_LIMIT), .WIDTH(1)) u_comp (
		.clk   (clk),
		.we    (comp_we),
		.waddr (comp_waddr),
		.wdata (comp_wdata),
		.raddr (n_q),
		.rdata (comp_rdata)
	);

	// Prime table, written at the fill count, read at k
	pfc_ram #(.DEPTH(PRIME_SLOTS), .WIDTH(AW)) u_primes (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (total_q[TW-1:0]),
		.wdata (n_q),
		.raddr (k_q[TW-1:0]),
		.rdata (tbl_rdata)
	);

	// Shared remainder unit for sieve and trial division
	pfc_div #(.DW(DW), .AW(AW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (p_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign div_exact = (div_rem == '0);
	assign cnt_inc   = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign cnt_fin   = (x_q > DW'(1)) ? cnt_inc : cnt_q;

	// Memory and divider strobes
	always_comb begin
		comp_we      = 1'b0;
		comp_waddr   = clr_q;
		comp_wdata   = 1'b0;
		tbl_we       = 1'b0;
		div_start    = 1'b0;
		div_dividend = x_q;
		unique case (state_q)
			S_CLEAR: begin
				comp_we    = 1'b1;
				comp_wdata = (clr_q < AW'(2));
			end
			S_N_CHK: begin
				tbl_we = !comp_rdata[0] && (total_q < KW'(PRIME_SLOTS));
			end
			S_K_CHK: begin
				comp_waddr   = prod_q[AW-1:0];
				comp_wdata   = 1'b1;
				div_dividend = DW'(n_q);
				if (prod_q < PW'(PRIME_LIMIT)) begin
					comp_we   = 1'b1;
					div_start = 1'b1;
				end
			end
			S_F_CHK: begin
				div_start = (p_q >= AW'(2)) && (CW'(prod_q) <= CW'(x_q));
			end
			S_F_DIV: begin
				div_dividend = div_quot;
				div_start    = div_done && div_exact;
			end
			default: begin
			end
		endcase
	end

	// Sequencer: clear pass, sieve, then trial division per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			n_q         <= '0;
			k_q         <= '0;
			total_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_cnt_q   <= '0;
		end else begin
			// Result register: load at the end of an item, clear on a taken beat
			if (state_q == S_F_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				out_cnt_q   <= cnt_fin;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(PRIME_LIMIT - 1)) begin
						n_q     <= AW'(2);
						state_q <= S_N_RD;
					end
				end
				S_N_RD: begin
					state_q <= S_N_CHK;
				end
				S_N_CHK: begin
					if (tbl_we) begin
						total_q <= total_q + 1'b1;
					end
					k_q     <= '0;
					state_q <= S_K_RD;
				end
				S_K_RD: begin
					state_q <= (k_q == total_q) ? S_N_NEXT : S_K_MUL;
				end
				S_K_MUL: begin
					state_q <= S_K_CHK;
				end
				S_K_CHK: begin
					state_q <= div_start ? S_K_DIV : S_N_NEXT;
				end
				S_K_DIV: begin
					if (div_done) begin
						if (div_exact) begin
							state_q <= S_N_NEXT;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_K_RD;
						end
					end
				end
				S_N_NEXT: begin
					if (n_q == AW'(PRIME_LIMIT - 1)) begin
						state_q <= S_IDLE;
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= S_N_RD;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						k_q     <= '0;
						state_q <= S_F_RD;
					end
				end
				S_F_RD: begin
					state_q <= (k_q == total_q) ? S_F_OUT : S_F_MUL;
				end
				S_F_MUL: begin
					state_q <= S_F_CHK;
				end
				S_F_CHK: begin
					state_q <= div_start ? S_F_DIV : S_F_OUT;
				end
				S_F_DIV: begin
					if (div_done) begin
						if (div_exact) begin
							cnt_q <= cnt_inc;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_F_RD;
						end
					end
				end
				S_F_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// Operand registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			x_q <= DW'(value);
		end else if (state_q == S_F_DIV && div_done && div_exact) begin
			x_q <= div_quot;
		end
		if (state_q == S_K_MUL) begin
			p_q    <= tbl_rdata;
			prod_q <= PW'(tbl_rdata) * PW'(n_q);
		end else if (state_q == S_F_MUL) begin
			p_q    <= tbl_rdata;
			prod_q <= PW'(tbl_rdata) * PW'(tbl_rdata);
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign factor_count = out_cnt_q;

endmodule

FILE: hw/rtl/prime_factor_counter_chk.sv
`include "prime_factor_counter_assert.svh"

module prime_factor_counter_chk #(
	parameter int VALUE_BITS = pfc_pkg::VALUE_BITS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [VALUE_BITS-1:0]       value,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [pfc_pkg::COUNT_W-1:0] factor_count
);

	import pfc_pkg::*;

	logic [1:0] pend_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
		end
	end

	`PFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(factor_count), "stalled result changed")
	`PFC_ASSERT_NOW(a_no_invented, out_valid, pend_q != 2'd0, "result without an accepted item")
	`PFC_ASSERT_NEXT(a_one_at_a_time, in_beat, !in_ready, "ready held high after accept")
	`PFC_ASSERT_NOW(a_depth, pend_q == 2'd2, !in_ready, "more than two items in flight")

endmodule

bind prime_factor_counter prime_factor_counter_chk #(.VALUE_BITS(VALUE_BITS)) u_chk (.*);
